### sv/tmcc_pkg.sv
// Shared types, constants and codes for the temperature monitor / cooler control block.
package tmcc_pkg;

	localparam int NOW_W      = 32;
	localparam int TEMP_W     = 12;
	localparam int IVL_W      = 16;
	localparam int DLY_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int SAMPLES_PER_ROUND_DEF = 5;

	// Fixed-point reciprocal used for the round average: floor(x/N) = (x*RECIP) >> RECIP_SHIFT,
	// exact for sums below 2^16 and N up to 16.
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	localparam logic [TEMP_W-1:0] REAL_OFFSET = 12'd3;
	localparam logic [TEMP_W-1:0] SLEW_STEP   = 12'd2;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_FINISH  = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COOLER_ENABLE   = 3'd0,
		CFG_COOL_OFF_BELOW  = 3'd1,
		CFG_COOL_ON_ABOVE   = 3'd2,
		CFG_SAMPLE_INTERVAL = 3'd3,
		CFG_FAN_OFF_DELAY   = 3'd4,
		CFG_ALARM_ARM_BELOW = 3'd5,
		CFG_ALARM_TRIP      = 3'd6,
		CFG_SLEW_CEILING    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic              cooler_enable;
		logic [TEMP_W-1:0] cool_off_below;
		logic [TEMP_W-1:0] cool_on_above;
		logic [IVL_W-1:0]  sample_interval_ms;
		logic [DLY_W-1:0]  fan_off_delay_ms;
		logic [TEMP_W-1:0] alarm_arm_below;
		logic [TEMP_W-1:0] alarm_trip_above;
		logic [TEMP_W-1:0] slew_ceiling;
	} cfg_t;

	typedef struct packed {
		logic [NOW_W-1:0]  now_ms;
		logic [TEMP_W-1:0] reading;
	} poll_t;

	typedef struct packed {
		logic              round_done;
		logic [TEMP_W-1:0] real_temp;
		logic [TEMP_W-1:0] shown_temp;
		logic              alarm_beep;
		logic              cooler_on_cmd;
		logic              cooler_off_cmd;
		logic              fan_off_cmd;
	} res_t;

endpackage

### sv/tmcc_if.sv
// Channel interfaces: poll input, result output and configuration write.
interface poll_if import tmcc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NOW_W-1:0]  now_ms;
	logic [TEMP_W-1:0] reading;

	modport source (output valid, now_ms, reading, input ready);
	modport sink (input valid, now_ms, reading, output ready);
endinterface

interface result_if import tmcc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              round_done;
	logic [TEMP_W-1:0] real_temp;
	logic [TEMP_W-1:0] shown_temp;
	logic              alarm_beep;
	logic              cooler_on_cmd;
	logic              cooler_off_cmd;
	logic              fan_off_cmd;

	modport source (output valid, round_done, real_temp, shown_temp, alarm_beep,
		cooler_on_cmd, cooler_off_cmd, fan_off_cmd, input ready);
	modport sink (input valid, round_done, real_temp, shown_temp, alarm_beep,
		cooler_on_cmd, cooler_off_cmd, fan_off_cmd, output ready);
endinterface

interface cfg_if import tmcc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/tmcc_cfg_regs.sv
// Configuration register file, written one register per beat.
module tmcc_cfg_regs import tmcc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	cfg_if.sink   cfg,
	output cfg_t  regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cooler_enable      <= 1'b0;
			regs_q.cool_off_below     <= 12'd250;
			regs_q.cool_on_above      <= 12'd300;
			regs_q.sample_interval_ms <= 16'd10000;
			regs_q.fan_off_delay_ms   <= 17'd60000;
			regs_q.alarm_arm_below    <= 12'd70;
			regs_q.alarm_trip_above   <= 12'd150;
			regs_q.slew_ceiling       <= 12'd150;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_COOLER_ENABLE:   regs_q.cooler_enable      <= cfg.data[0];
				CFG_COOL_OFF_BELOW:  regs_q.cool_off_below     <= cfg.data[TEMP_W-1:0];
				CFG_COOL_ON_ABOVE:   regs_q.cool_on_above      <= cfg.data[TEMP_W-1:0];
				CFG_SAMPLE_INTERVAL: regs_q.sample_interval_ms <= cfg.data[IVL_W-1:0];
				CFG_FAN_OFF_DELAY:   regs_q.fan_off_delay_ms   <= cfg.data[DLY_W-1:0];
				CFG_ALARM_ARM_BELOW: regs_q.alarm_arm_below    <= cfg.data[TEMP_W-1:0];
				CFG_ALARM_TRIP:      regs_q.alarm_trip_above   <= cfg.data[TEMP_W-1:0];
				CFG_SLEW_CEILING:    regs_q.slew_ceiling       <= cfg.data[TEMP_W-1:0];
			endcase
		end
	end

endmodule

### sv/tmcc_core.sv
// Round state machine and finish-poll datapath: average, slew, alarm, cooler and fan timer.
module tmcc_core import tmcc_pkg::*; #(
	parameter int SAMPLES_PER_ROUND = SAMPLES_PER_ROUND_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  fire,
	input  poll_t item,
	output res_t  res
);

	localparam int SUM_W  = $clog2(SAMPLES_PER_ROUND * 4095 + 1);
	localparam int CNT_W  = $clog2(SAMPLES_PER_ROUND + 1);
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'(1) << RECIP_SHIFT) / SAMPLES_PER_ROUND + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_ROUND);

	phase_t            phase_q, phase_d;
	logic [NOW_W-1:0]  next_round_q, next_round_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [TEMP_W-1:0] real_q, real_d;
	logic [TEMP_W-1:0] shown_q, shown_d;
	logic              track_q, track_d;
	logic              armed_q, armed_d;
	logic [NOW_W-1:0]  fan_time_q, fan_time_d;
	logic              pend_q, pend_d;

	logic [PROD_W-1:0] prod;
	logic [TEMP_W-1:0] avg;
	logic [TEMP_W-1:0] base;
	logic              armed_pre;
	res_t              res_d;

	// Sample count is always SAMPLES_PER_ROUND at finish, so the average is a constant divide.
	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign avg  = prod[RECIP_SHIFT +: TEMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (fire) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_round_q <= '0;
			cnt_q        <= '0;
			sum_q        <= '0;
			real_q       <= '0;
			shown_q      <= '0;
			track_q      <= 1'b0;
			armed_q      <= 1'b0;
			fan_time_q   <= '0;
			pend_q       <= 1'b0;
		end else if (fire) begin
			next_round_q <= next_round_d;
			cnt_q        <= cnt_d;
			sum_q        <= sum_d;
			real_q       <= real_d;
			shown_q      <= shown_d;
			track_q      <= track_d;
			armed_q      <= armed_d;
			fan_time_q   <= fan_time_d;
			pend_q       <= pend_d;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		next_round_d = next_round_q;
		cnt_d        = cnt_q;
		sum_d        = sum_q;
		real_d       = real_q;
		shown_d      = shown_q;
		track_d      = track_q;
		armed_d      = armed_q;
		fan_time_d   = fan_time_q;
		pend_d       = pend_q;
		base         = shown_q;
		armed_pre    = armed_q;
		res_d        = '0;

		unique case (phase_q)
			PH_IDLE: begin
				if (item.now_ms > next_round_q) begin
					phase_d = PH_COLLECT;
					cnt_d   = '0;
					sum_d   = '0;
				end
			end
			PH_COLLECT: begin
				sum_d = sum_q + SUM_W'(item.reading);
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_d >= CNT_LAST)
					phase_d = PH_FINISH;
			end
			PH_FINISH: begin
				res_d.round_done = 1'b1;
				phase_d      = PH_IDLE;
				next_round_d = item.now_ms + NOW_W'(cfg.sample_interval_ms);
				real_d       = (avg > REAL_OFFSET) ? avg - REAL_OFFSET : '0;

				// Display slew: jump when hot, when starting to track or when within one, else step by two.
				if (real_d >= cfg.slew_ceiling) begin
					shown_d = real_d;
					track_d = 1'b0;
				end else begin
					base    = track_q ? shown_q : real_d;
					track_d = 1'b1;
					if (base == real_d)
						shown_d = base;
					else if ((base + 12'd1 == real_d && base != '1) ||
						(real_d + 12'd1 == base && real_d != '1))
						shown_d = real_d;
					else if (base < real_d)
						shown_d = base + SLEW_STEP;
					else
						shown_d = base - SLEW_STEP;
				end

				// Arm before trip: a round that does both beeps and ends disarmed.
				armed_pre = armed_q | (real_d < cfg.alarm_arm_below);
				armed_d   = armed_pre;
				if (armed_pre && real_d > cfg.alarm_trip_above) begin
					res_d.alarm_beep = 1'b1;
					armed_d          = 1'b0;
				end

				res_d.fan_off_cmd = pend_q && (item.now_ms > fan_time_q);

				if (cfg.cooler_enable) begin
					if (real_d < cfg.cool_off_below) begin
						res_d.cooler_off_cmd = 1'b1;
						fan_time_d = item.now_ms + NOW_W'(cfg.fan_off_delay_ms);
						pend_d     = 1'b1;
					end
					if (real_d > cfg.cool_on_above) begin
						res_d.cooler_on_cmd = 1'b1;
						pend_d = 1'b0;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		res_d.real_temp  = real_d;
		res_d.shown_temp = shown_d;
	end

	assign res = res_d;

endmodule

### sv/temperature_monitor_cooler_control.sv
// Top level: poll input stage, round core, result register and configuration registers.
//
//  channel  dir  beat                                   notes
//  poll     in   now_ms[31:0], reading[11:0]             one beat per poll
//  result   out  round_done, real/shown temp, 4 pulses   one beat per poll
//  cfg      in   index[2:0], data[16:0]                  always ready
//
// One poll per cycle sustained while the result side is ready; a poll passes through the input
// stage and then the result register. All of a poll's work, including the constant-reciprocal
// average multiply, sits between the input stage and the result register.
// arst_n clears the handshake state, the round state and the configuration registers to their defaults.
// A stalled result holds the result register; the input stage still takes one more beat if it is empty.
module temperature_monitor_cooler_control import tmcc_pkg::*; #(
	parameter int SAMPLES_PER_ROUND = SAMPLES_PER_ROUND_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	poll_if.sink      poll,
	result_if.source  result,
	cfg_if.sink       cfg
);

	cfg_t  regs;
	poll_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;
	logic  adv;
	logic  fire;

	assign adv        = !out_valid_q || result.ready;
	assign fire       = valid_s1 && adv;
	assign poll.ready = !valid_s1 || adv;

	tmcc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tmcc_core #(
		.SAMPLES_PER_ROUND (SAMPLES_PER_ROUND)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (regs),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			item_s1.now_ms  <= poll.now_ms;
			item_s1.reading <= poll.reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign result.valid          = out_valid_q;
	assign result.round_done     = res_q.round_done;
	assign result.real_temp      = res_q.real_temp;
	assign result.shown_temp     = res_q.shown_temp;
	assign result.alarm_beep     = res_q.alarm_beep;
	assign result.cooler_on_cmd  = res_q.cooler_on_cmd;
	assign result.cooler_off_cmd = res_q.cooler_off_cmd;
	assign result.fan_off_cmd    = res_q.fan_off_cmd;

	// Pulses only come out of a finish poll.
	a_pulse_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.alarm_beep || result.cooler_on_cmd ||
		result.cooler_off_cmd || result.fan_off_cmd) |-> result.round_done)
		else $error("pulse without round_done");

	// Cooler commands need threshold control enabled.
	a_cooler_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.cooler_on_cmd || result.cooler_off_cmd) |-> regs.cooler_enable)
		else $error("cooler command while disabled");

	// At or above the slew ceiling the display follows the real value.
	a_slew_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.round_done && (result.real_temp >= regs.slew_ceiling)
		|-> result.shown_temp == result.real_temp)
		else $error("shown temp not following above ceiling");

	// A result beat that is taken is replaced only by an item from the input stage.
	a_out_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && adv |=> !out_valid_q)
		else $error("result beat without input");

endmodule
